@@ rtl/tmsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tmsq_pkg
// Types and constants shared by the timed H-bridge motor sequencer.
// ----------------------------------------------------------------------------
package tmsq_pkg;

  // number of drive slots in the result item
  localparam int unsigned NUM_DRIVES = 3;

  localparam logic [31:0] US_PER_MS = 32'd1000;
  localparam logic [22:0] MAX_MS    = 23'd4294967;

  typedef enum logic [3:0] {
    MODE_STAGE    = 4'd0,
    MODE_START    = 4'd1,
    MODE_TICK     = 4'd2,
    MODE_PAUSE    = 4'd3,
    MODE_RESUME   = 4'd4,
    MODE_ABORT    = 4'd5,
    MODE_RUN      = 4'd6,
    MODE_STOP     = 4'd7,
    MODE_STOP_ALL = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    STATUS_IDLE      = 3'd0,
    STATUS_RUNNING   = 3'd1,
    STATUS_PAUSED    = 3'd2,
    STATUS_COMPLETED = 3'd3,
    STATUS_ABORTED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_DUTY_LIMIT  = 2'd0,
    CFG_INVERT_MASK = 2'd1,
    CFG_EN_POLARITY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] duty_limit;
    logic [2:0] direction_invert_mask;
    logic       enable_active_high;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  motor;
    logic [22:0] duration_ms;
    logic [7:0]  speed;
    logic        direction;
  } in_item_t;

  typedef struct packed {
    logic [7:0] right_duty_0;
    logic [7:0] left_duty_0;
    logic [7:0] right_duty_1;
    logic [7:0] left_duty_1;
    logic [7:0] right_duty_2;
    logic [7:0] left_duty_2;
    logic [2:0] enable_levels;
    logic [2:0] batch_status;
  } out_item_t;

endpackage

@@ rtl/tmsq_drive.sv @@
// ----------------------------------------------------------------------------
// tmsq_drive
// Half-bridge duty and enable pin level generation for each motor.
// ----------------------------------------------------------------------------
module tmsq_drive #(
  parameter int unsigned MOTOR_COUNT = 3
) (
  input  logic [MOTOR_COUNT-1:0] running_i,
  input  logic [MOTOR_COUNT-1:0] direction_i,
  input  logic [7:0]             speed_i [MOTOR_COUNT],
  input  tmsq_pkg::cfg_t         cfg_i,
  output logic [7:0]             right_duty_o [tmsq_pkg::NUM_DRIVES],
  output logic [7:0]             left_duty_o [tmsq_pkg::NUM_DRIVES],
  output logic [tmsq_pkg::NUM_DRIVES-1:0] enable_o
);

  for (genvar i = 0; i < tmsq_pkg::NUM_DRIVES; i++) begin : g_drive
    if (i < MOTOR_COUNT) begin : g_used
      logic [7:0] duty;
      logic       drive_right;

      assign duty = (speed_i[i] < cfg_i.duty_limit) ? speed_i[i] : cfg_i.duty_limit;
      // clockwise drives the right side unless the motor is inverted
      assign drive_right = (~direction_i[i]) ^ cfg_i.direction_invert_mask[i];

      assign right_duty_o[i] = (running_i[i] && drive_right) ? duty : 8'd0;
      assign left_duty_o[i]  = (running_i[i] && !drive_right) ? duty : 8'd0;
      assign enable_o[i]     = (running_i[i] == cfg_i.enable_active_high);
    end else begin : g_unused
      assign right_duty_o[i] = 8'd0;
      assign left_duty_o[i]  = 8'd0;
      assign enable_o[i]     = 1'b0;
    end
  end

endmodule

@@ rtl/timed_hbridge_motor_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// timed_hbridge_motor_sequencer_core
// Timed batch sequencer and direct control for up to three H-bridge motors.
// ----------------------------------------------------------------------------
// Commands enter on the in_* valid/ready channel, one per transfer: stage a
// timed move, start/pause/resume/abort the batch, a microsecond tick, or
// direct run/stop/stop-all. Every command gives exactly one result on the
// out_* channel holding both duties of each motor, the enable pin levels and
// the batch status after that command.
// A command is taken into an input register, then the state update and the
// drive outputs are written into the result register. Throughput is one
// command per cycle while the receiver takes results; the update is a set
// of per-motor countdowns and selects plus one constant multiply of the
// staged time.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; after that in_ready_o drops until the result
// is taken. Reset halts all motors, clears the batch and staged moves and
// loads duty_limit 255, no inversion and active-high enables. The cfg_* port
// writes a register at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module timed_hbridge_motor_sequencer_core #(
  parameter int unsigned MOTOR_COUNT = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmsq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmsq_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);

  localparam int unsigned Mc = MOTOR_COUNT;

  // configuration
  tmsq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_limit            <= 8'd255;
      cfg_q.direction_invert_mask <= 3'd0;
      cfg_q.enable_active_high    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmsq_pkg::CFG_DUTY_LIMIT:  cfg_q.duty_limit            <= cfg_wdata_i;
        tmsq_pkg::CFG_INVERT_MASK: cfg_q.direction_invert_mask <= cfg_wdata_i[2:0];
        tmsq_pkg::CFG_EN_POLARITY: cfg_q.enable_active_high    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic               s1_valid_q;
  tmsq_pkg::in_item_t s1_item_q;
  logic               s1_adv;
  logic               out_valid_q;
  tmsq_pkg::out_item_t out_item_q, out_item_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // sequencer state
  logic [31:0]   remaining_q [Mc];
  logic [31:0]   remaining_d [Mc];
  logic [31:0]   staged_us_q [Mc];
  logic [31:0]   staged_us_d [Mc];
  logic [7:0]    staged_speed_q [Mc];
  logic [7:0]    staged_speed_d [Mc];
  logic [7:0]    speed_q [Mc];
  logic [7:0]    speed_d [Mc];
  logic [Mc-1:0] staged_dir_q, staged_dir_d;
  logic [Mc-1:0] staged_valid_q, staged_valid_d;
  logic [Mc-1:0] active_q, active_d;
  logic [Mc-1:0] dir_q, dir_d;
  logic [Mc-1:0] running_q, running_d;
  logic          paused_q, paused_d;
  logic          busy_q, busy_d;

  logic [Mc-1:0]     sel;
  logic [22:0]       dur_sat;
  logic [31:0]       dur_us;
  tmsq_pkg::status_e event_st;

  for (genvar i = 0; i < Mc; i++) begin : g_sel
    assign sel[i] = (s1_item_q.motor == 2'(i));
  end

  assign dur_sat = (s1_item_q.duration_ms > tmsq_pkg::MAX_MS) ?
                   tmsq_pkg::MAX_MS : s1_item_q.duration_ms;
  assign dur_us  = 32'(32'(dur_sat) * tmsq_pkg::US_PER_MS);

  always_comb begin
    remaining_d    = remaining_q;
    staged_us_d    = staged_us_q;
    staged_speed_d = staged_speed_q;
    speed_d        = speed_q;
    staged_dir_d   = staged_dir_q;
    staged_valid_d = staged_valid_q;
    active_d       = active_q;
    dir_d          = dir_q;
    running_d      = running_q;
    paused_d       = paused_q;
    busy_d         = busy_q;
    event_st       = tmsq_pkg::STATUS_IDLE;

    case (s1_item_q.mode)
      tmsq_pkg::MODE_STAGE: begin
        if (s1_item_q.duration_ms != 23'd0) begin
          for (int i = 0; i < Mc; i++) begin
            if (sel[i]) begin
              staged_us_d[i]    = dur_us;
              staged_speed_d[i] = s1_item_q.speed;
              staged_dir_d[i]   = s1_item_q.direction;
              staged_valid_d[i] = 1'b1;
            end
          end
        end
      end
      tmsq_pkg::MODE_START: begin
        if (!busy_q) begin
          if (staged_valid_q == '0) begin
            event_st = tmsq_pkg::STATUS_COMPLETED;
          end else begin
            for (int i = 0; i < Mc; i++) begin
              if (staged_valid_q[i]) begin
                remaining_d[i] = staged_us_q[i];
                speed_d[i]     = staged_speed_q[i];
                dir_d[i]       = staged_dir_q[i];
                running_d[i]   = 1'b1;
              end
            end
            active_d       = staged_valid_q;
            staged_valid_d = '0;
            busy_d         = 1'b1;
            paused_d       = 1'b0;
          end
        end
      end
      tmsq_pkg::MODE_TICK: begin
        if (busy_q && !paused_q) begin
          for (int i = 0; i < Mc; i++) begin
            if (active_q[i]) begin
              if (remaining_q[i] != 32'd0) begin
                remaining_d[i] = remaining_q[i] - 32'd1;
              end
              if (remaining_q[i] <= 32'd1) begin
                active_d[i]  = 1'b0;
                running_d[i] = 1'b0;
              end
            end
          end
          if (active_d == '0) begin
            busy_d   = 1'b0;
            event_st = tmsq_pkg::STATUS_COMPLETED;
          end
        end
      end
      tmsq_pkg::MODE_PAUSE: begin
        if (busy_q && !paused_q) begin
          paused_d  = 1'b1;
          running_d = running_q & ~active_q;
        end
      end
      tmsq_pkg::MODE_RESUME: begin
        if (busy_q && paused_q) begin
          paused_d  = 1'b0;
          running_d = running_q | active_q;
        end
      end
      tmsq_pkg::MODE_ABORT: begin
        if (busy_q) begin
          running_d = running_q & ~active_q;
          for (int i = 0; i < Mc; i++) begin
            remaining_d[i] = 32'd0;
          end
          active_d = '0;
          busy_d   = 1'b0;
          paused_d = 1'b0;
          event_st = tmsq_pkg::STATUS_ABORTED;
        end
      end
      tmsq_pkg::MODE_RUN: begin
        for (int i = 0; i < Mc; i++) begin
          if (sel[i]) begin
            speed_d[i]   = s1_item_q.speed;
            dir_d[i]     = s1_item_q.direction;
            running_d[i] = 1'b1;
          end
        end
      end
      tmsq_pkg::MODE_STOP: begin
        running_d = running_q & ~sel;
      end
      tmsq_pkg::MODE_STOP_ALL: begin
        running_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Mc; i++) begin
        remaining_q[i]    <= 32'd0;
        staged_us_q[i]    <= 32'd0;
        staged_speed_q[i] <= 8'd0;
        speed_q[i]        <= 8'd0;
      end
      staged_dir_q   <= '0;
      staged_valid_q <= '0;
      active_q       <= '0;
      dir_q          <= '0;
      running_q      <= '0;
      paused_q       <= 1'b0;
      busy_q         <= 1'b0;
    end else if (s1_adv) begin
      remaining_q    <= remaining_d;
      staged_us_q    <= staged_us_d;
      staged_speed_q <= staged_speed_d;
      speed_q        <= speed_d;
      staged_dir_q   <= staged_dir_d;
      staged_valid_q <= staged_valid_d;
      active_q       <= active_d;
      dir_q          <= dir_d;
      running_q      <= running_d;
      paused_q       <= paused_d;
      busy_q         <= busy_d;
    end
  end

  // drive outputs from the state after this command
  logic [7:0] right_duty [tmsq_pkg::NUM_DRIVES];
  logic [7:0] left_duty [tmsq_pkg::NUM_DRIVES];
  logic [tmsq_pkg::NUM_DRIVES-1:0] enable_lv;

  tmsq_drive #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_drive (
    .running_i   (running_d),
    .direction_i (dir_d),
    .speed_i     (speed_d),
    .cfg_i       (cfg_q),
    .right_duty_o(right_duty),
    .left_duty_o (left_duty),
    .enable_o    (enable_lv)
  );

  always_comb begin
    out_item_d.right_duty_0  = right_duty[0];
    out_item_d.left_duty_0   = left_duty[0];
    out_item_d.right_duty_1  = right_duty[1];
    out_item_d.left_duty_1   = left_duty[1];
    out_item_d.right_duty_2  = right_duty[2];
    out_item_d.left_duty_2   = left_duty[2];
    out_item_d.enable_levels = enable_lv;
    if (event_st != tmsq_pkg::STATUS_IDLE) begin
      out_item_d.batch_status = event_st;
    end else if (busy_d) begin
      out_item_d.batch_status = paused_d ? tmsq_pkg::STATUS_PAUSED : tmsq_pkg::STATUS_RUNNING;
    end else begin
      out_item_d.batch_status = tmsq_pkg::STATUS_IDLE;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a batch in progress always has at least one timed motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (active_q != '0))
    else $error("batch busy flag and active motors disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> busy_q)
    else $error("paused without a batch");

  // no state update while a result waits to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(running_q) && $stable(active_q)))
    else $error("state changed during an output stall");

endmodule
